/* rtl/polling_bus_master_receiver_assert.svh */
// Assertion macros used by the checker file.
`ifndef POLLING_BUS_MASTER_RECEIVER_ASSERT_SVH
`define POLLING_BUS_MASTER_RECEIVER_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define PBMR_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbmr assertion failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define PBMR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbmr assertion failed");

`endif

/* rtl/pbmr_pkg.sv */
`default_nettype none
package pbmr_pkg;

    localparam int FUNC_W          = 3;
    localparam int BYTE_W          = 8;
    localparam int ID_W            = 7;
    localparam int LEN_W           = 6;
    localparam int OUT_W           = 40;
    localparam int MAX_DEVICES_DEF = 128;

    localparam logic [ID_W-1:0]   FIRST_ID     = 7'd1;
    localparam logic [ID_W-1:0]   HIGHEST_RST  = 7'd4;
    localparam logic [ID_W-1:0]   TOP_ID       = 7'd127;
    localparam logic [BYTE_W-1:0] TICK_MAX     = 8'd255;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR   = 3'd0,
        FUNC_ADD     = 3'd1,
        FUNC_REMOVE  = 3'd2,
        FUNC_TICK    = 3'd3,
        FUNC_POLL    = 3'd4,
        FUNC_RX      = 3'd5,
        FUNC_TIMEOUT = 3'd6
    } func_t;

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_OK      = 3'd2,
        ST_BAD     = 3'd3,
        ST_TIMEOUT = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        PR_NONE  = 2'd0,
        PR_FOUND = 2'd1,
        PR_LOST  = 2'd2
    } pres_t;

    // One map entry: poll flag and presence flag of a device id.
    typedef struct packed {
        logic polled;
        logic present;
    } map_word_t;

    typedef struct packed {
        logic            en;
        logic [ID_W-1:0] id;
        map_word_t       word;
    } map_wr_t;

    // Result layout, last member in the lowest bits.
    typedef struct packed {
        logic              busy_res;
        logic [LEN_W-1:0]  payload_length;
        logic              text_packet;
        pres_t             presence_change;
        logic              ack_byte;
        logic              ack_valid;
        status_t           reply_status;
        logic [BYTE_W-1:0] data_byte;
        logic              data_valid;
        logic [BYTE_W-1:0] poll_byte;
        logic              poll_sent;
        logic [ID_W-1:0]   device_id;
    } result_t;

endpackage
`default_nettype wire

/* rtl/polling_bus_master_receiver.sv */
// Channel   | Group            | Contents (lowest bits first)
// ----------+------------------+-----------------------------------------------
// input     | s_axis_*         | tuser: func[2:0]; tdata: value[7:0]
// output    | m_axis_*         | tdata: see field list at the port
// config    | cfg_wr_en/_data  | poll_delay_ms[7:0]
//
// One transaction enters per cycle while the output is not stalled. Each result
// sits in stage one for the device-map read, then in the output register.
// Map state sits in a synchronous RAM; a write to the entry read in the same
// cycle is forwarded, and per-entry valid flops make reset and clear-all
// take effect at once, with no clearing pass.
// A stalled output holds the pipeline; input stays ready while stage one
// drains into an empty or departing output register.
`default_nettype none
module polling_bus_master_receiver #(
    parameter int MAX_DEVICES = pbmr_pkg::MAX_DEVICES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output      logic                          s_axis_tready,
    // value[7:0]
    input  wire logic [pbmr_pkg::BYTE_W-1:0]   s_axis_tdata,
    // func[2:0]
    input  wire logic [pbmr_pkg::FUNC_W-1:0]   s_axis_tuser,
    output      logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // device_id[6:0], poll_sent[7], poll_byte[15:8], data_valid[16],
    // data_byte[24:17], reply_status[27:25], ack_valid[28], ack_byte[29],
    // presence_change[31:30], text_packet[32], payload_length[38:33],
    // busy_res[39]
    output      logic [pbmr_pkg::OUT_W-1:0]    m_axis_tdata,
    input  wire logic                          cfg_wr_en,
    input  wire logic [pbmr_pkg::BYTE_W-1:0]   cfg_wr_data
);
    import pbmr_pkg::*;

    // Next id after cur in round-robin order, wrapping to the first id.
    function automatic logic [ID_W-1:0] next_id(input logic [ID_W-1:0] cur,
                                                input logic [ID_W-1:0] hi);
        logic [ID_W:0] nx;
        nx = {1'b0, cur} + 8'd1;
        if ((nx > {1'b0, hi}) || (nx > {1'b0, TOP_ID}))
        begin
            return FIRST_ID;
        end
        return nx[ID_W-1:0];
    endfunction

    // Pipeline control
    logic              in_accept;
    logic              s1_fire;
    logic              s1_valid_reg;
    func_t             s1_func_reg;
    logic [BYTE_W-1:0] s1_value_reg;
    logic              out_valid_reg;
    result_t           out_data_reg;

    // Block state
    logic [ID_W-1:0]   cur_reg,   cur_next;
    logic [ID_W-1:0]   hi_reg,    hi_next;
    logic [BYTE_W-1:0] tick_reg,  tick_next;
    logic              recv_reg,  recv_next;
    logic [ID_W-1:0]   bc_reg,    bc_next;
    logic [ID_W-1:0]   fe_reg,    fe_next;
    logic [BYTE_W-1:0] sum_reg,   sum_next;
    logic              tf_reg,    tf_next;
    logic [BYTE_W-1:0] delay_reg, delay_next;

    // Map access
    logic              map_clr;
    logic [ID_W-1:0]   rd_id;
    map_wr_t           map_wr;
    map_word_t         map_q;

    // Working values of the reply deframer
    logic [ID_W-1:0]   bc_inc;
    logic [ID_W-1:0]   fe_work;
    logic [BYTE_W-1:0] sum_base;
    logic [BYTE_W-1:0] sum_add;
    logic              id_ok;
    result_t           res;

    assign s1_fire       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_fire;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Read address: state as it stands once the item in stage one retires.
    always_comb
    begin
        case (func_t'(s_axis_tuser))
            FUNC_POLL: rd_id = next_id(cur_next, hi_next);
            default:   rd_id = cur_next;
        endcase
    end

    pbmr_map #(
        .MAX_DEVICES (MAX_DEVICES)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_id   (rd_id),
        .wr      (map_wr),
        .clr     (map_clr),
        .rd_word (map_q)
    );

    // only ids 1..127 that fit in the map are acted on
    assign id_ok   = (s1_value_reg != '0) && !s1_value_reg[BYTE_W-1] &&
                     (32'(s1_value_reg) < MAX_DEVICES);
    assign bc_inc  = bc_reg + 7'd1;
    assign fe_work = (bc_inc == 7'd1) ? ({1'b0, s1_value_reg[LEN_W-1:0]} + 7'd1) : fe_reg;
    assign sum_base = (bc_inc == 7'd1) ? '0 : sum_reg;
    assign sum_add  = sum_base + s1_value_reg;

    // Stage one: decide the item against state and the map entry.
    always_comb
    begin
        cur_next   = cur_reg;
        hi_next    = hi_reg;
        tick_next  = tick_reg;
        recv_next  = recv_reg;
        bc_next    = bc_reg;
        fe_next    = fe_reg;
        sum_next   = sum_reg;
        tf_next    = tf_reg;
        delay_next = delay_reg;
        map_clr    = 1'b0;
        map_wr     = '{en: 1'b0, id: cur_reg, word: '0};
        res        = '0;

        if (s1_fire)
        begin
            case (s1_func_reg)
                FUNC_CLEAR:
                begin
                    cur_next   = FIRST_ID;
                    hi_next    = HIGHEST_RST;
                    recv_next  = 1'b0;
                    bc_next    = '0;
                    fe_next    = '0;
                    sum_next   = '0;
                    tf_next    = 1'b0;
                    delay_next = '0;
                    map_clr    = 1'b1;
                end
                FUNC_ADD:
                begin
                    if (id_ok)
                    begin
                        map_wr = '{en: 1'b1, id: s1_value_reg[ID_W-1:0],
                                   word: '{polled: 1'b1, present: 1'b0}};
                        if (hi_reg < s1_value_reg[ID_W-1:0])
                        begin
                            hi_next = s1_value_reg[ID_W-1:0];
                        end
                    end
                end
                FUNC_REMOVE:
                begin
                    if (id_ok)
                    begin
                        map_wr = '{en: 1'b1, id: s1_value_reg[ID_W-1:0], word: '0};
                    end
                end
                FUNC_TICK:
                begin
                    if (tick_reg != TICK_MAX)
                    begin
                        tick_next = tick_reg + 8'd1;
                    end
                end
                FUNC_POLL:
                begin
                    if (!recv_reg && (tick_reg >= delay_reg))
                    begin
                        tick_next = '0;
                        cur_next  = next_id(cur_reg, hi_reg);
                        if (map_q.polled)
                        begin
                            res.poll_sent = 1'b1;
                            res.poll_byte = {1'b1, cur_next};
                            recv_next     = 1'b1;
                            bc_next       = '0;
                            sum_next      = '0;
                        end
                    end
                end
                FUNC_RX:
                begin
                    if (recv_reg)
                    begin
                        bc_next  = bc_inc;
                        fe_next  = fe_work;
                        sum_next = sum_add;
                        if ((bc_inc == 7'd1) && (s1_value_reg == '0))
                        begin
                            // empty reply: the device answered with nothing to say
                            sum_next         = '0;
                            recv_next        = 1'b0;
                            res.reply_status = ST_EMPTY;
                            if (!map_q.present)
                            begin
                                map_wr = '{en: 1'b1, id: cur_reg,
                                           word: '{polled: map_q.polled, present: 1'b1}};
                                res.presence_change = PR_FOUND;
                            end
                        end
                        else
                        begin
                            if (bc_inc == 7'd1)
                            begin
                                tf_next = s1_value_reg[BYTE_W-1];
                            end
                            if (bc_inc > fe_work)
                            begin
                                recv_next     = 1'b0;
                                res.ack_valid = 1'b1;
                                if (sum_add == '0)
                                begin
                                    res.reply_status = ST_OK;
                                    if (!map_q.present)
                                    begin
                                        map_wr = '{en: 1'b1, id: cur_reg,
                                                   word: '{polled: map_q.polled,
                                                           present: 1'b1}};
                                        res.presence_change = PR_FOUND;
                                    end
                                end
                                else
                                begin
                                    res.reply_status = ST_BAD;
                                    res.ack_byte     = 1'b1;
                                end
                            end
                            else if (bc_inc > 7'd1)
                            begin
                                res.data_valid = 1'b1;
                                res.data_byte  = s1_value_reg;
                            end
                        end
                    end
                end
                FUNC_TIMEOUT:
                begin
                    if (recv_reg)
                    begin
                        recv_next        = 1'b0;
                        res.reply_status = ST_TIMEOUT;
                        if (map_q.present)
                        begin
                            map_wr = '{en: 1'b1, id: cur_reg,
                                       word: '{polled: map_q.polled, present: 1'b0}};
                            res.presence_change = PR_LOST;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        res.device_id      = cur_next;
        res.text_packet    = tf_next;
        res.payload_length = (fe_next != '0) ? LEN_W'(fe_next - 7'd1) : '0;
        res.busy_res       = recv_next;
    end

    // Control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_reg       <= FIRST_ID;
            hi_reg        <= HIGHEST_RST;
            tick_reg      <= '0;
            recv_reg      <= 1'b0;
            bc_reg        <= '0;
            fe_reg        <= '0;
            sum_reg       <= '0;
            tf_reg        <= 1'b0;
            delay_reg     <= '0;
        end
        else
        begin
            // advance stage one; drop it once it retires with no successor
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            cur_reg  <= cur_next;
            hi_reg   <= hi_next;
            tick_reg <= tick_next;
            recv_reg <= recv_next;
            bc_reg   <= bc_next;
            fe_reg   <= fe_next;
            sum_reg  <= sum_next;
            tf_reg   <= tf_next;

            // the user must write only while idle, so writes never meet a clear-all; not enforced here
            if (cfg_wr_en)
            begin
                delay_reg <= cfg_wr_data;
            end
            else
            begin
                delay_reg <= delay_next;
            end
        end
    end

    // Payload: hold the item in stage one and the result until taken
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg  <= func_t'(s_axis_tuser);
            s1_value_reg <= s_axis_tdata;
        end
        if (s1_fire)
        begin
            out_data_reg <= res;
        end
    end

endmodule
`default_nettype wire

/* rtl/pbmr_ram.sv */
`default_nettype none
module pbmr_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/pbmr_map.sv */
`default_nettype none
module pbmr_map #(
    parameter int MAX_DEVICES = 128
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      rd_en,
    input  wire logic [pbmr_pkg::ID_W-1:0] rd_id,
    input  wire pbmr_pkg::map_wr_t         wr,
    input  wire logic                      clr,
    output      pbmr_pkg::map_word_t       rd_word
);
    import pbmr_pkg::*;

    localparam int AW = $clog2(MAX_DEVICES);

    logic             rd_ok;
    logic             wr_ok;
    logic             wr_go;
    logic [1:0]       ram_q;
    logic [AW-1:0]    rd_addr_reg;
    logic             rd_ok_reg;
    logic             fwd_hit_reg;
    map_word_t        fwd_word_reg;
    logic [MAX_DEVICES-1:0] valid_reg;

    assign rd_ok = (32'(rd_id) < MAX_DEVICES);
    assign wr_ok = (32'(wr.id) < MAX_DEVICES);
    assign wr_go = wr.en && wr_ok;

    pbmr_ram #(
        .WIDTH ($bits(map_word_t)),
        .DEPTH (MAX_DEVICES)
    ) u_ram (
        .clk   (clk),
        .we    (wr_go),
        .waddr (wr.id[AW-1:0]),
        .wdata (wr.word),
        .re    (rd_en),
        .raddr (rd_id[AW-1:0]),
        .rdata (ram_q)
    );

    // Entries never written since the last clear read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clr)
        begin
            valid_reg <= '0;
        end
        else if (wr_go)
        begin
            valid_reg[wr.id[AW-1:0]] <= 1'b1;
        end
    end

    // Capture a write to the entry being read in the same cycle.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_addr_reg  <= rd_id[AW-1:0];
            rd_ok_reg    <= rd_ok;
            fwd_hit_reg  <= wr_go && (wr.id == rd_id);
            fwd_word_reg <= wr.word;
        end
    end

    always_comb
    begin
        rd_word = '0;
        if (rd_ok_reg && valid_reg[rd_addr_reg])
        begin
            rd_word = fwd_hit_reg ? fwd_word_reg : map_word_t'(ram_q);
        end
    end

endmodule
`default_nettype wire

/* rtl/pbmr_check.sv */
`default_nettype none
`include "polling_bus_master_receiver_assert.svh"
module pbmr_check (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [pbmr_pkg::OUT_W-1:0]  m_axis_tdata
);
    import pbmr_pkg::*;

    result_t res;

    assign res = result_t'(m_axis_tdata);

    `PBMR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // a sent poll opens a reply window and carries the address byte
    `PBMR_ASSERT_IMPL(a_poll_byte, m_axis_tvalid && res.poll_sent, res.busy_res && (res.poll_byte == {1'b1, res.device_id}))

    `PBMR_ASSERT_IMPL(a_one_event, m_axis_tvalid, !(res.data_valid && res.ack_valid))

    // an ack closes the frame and matches the checksum verdict
    `PBMR_ASSERT_IMPL(a_ack_ends, m_axis_tvalid && res.ack_valid, !res.busy_res && ((res.reply_status == ST_OK) || (res.reply_status == ST_BAD)) && (res.ack_byte == (res.reply_status == ST_BAD)))

endmodule

bind polling_bus_master_receiver pbmr_check u_pbmr_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
